@@ design/uts_pkg.sv @@
// ----------------------------------------------------------------------------
// uts_pkg
// Shared types and constants of the 8N1 transmitter with byte queue.
// ----------------------------------------------------------------------------
`default_nettype none

package uts_pkg;

  // request kinds
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PHASE_W  = 4;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned BITSEL_W = 3;

  // framing phases: start bit, data bits 1..8, stop bit
  localparam logic [PHASE_W-1:0] PHASE_START = 4'd0;
  localparam logic [PHASE_W-1:0] PHASE_STOP  = 4'd9;

  localparam logic LINE_IDLE  = 1'b1;
  localparam logic LINE_START = 1'b0;
  localparam logic LINE_STOP  = 1'b1;

  // one result
  typedef struct packed {
    logic               tx_line;
    logic               busy_res;
    logic [COUNT_W-1:0] queue_count;
    logic               push_dropped;
  } res_t;

  // queue memory controls from the framer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ design/uart_tx_serializer_fifo.sv @@
// ----------------------------------------------------------------------------
// uart_tx_serializer_fifo
// 8N1 UART transmitter fed from a byte queue held in a synchronous memory.
// ----------------------------------------------------------------------------
// Each request is a push (in_cmd = 0, appends in_data_byte to the queue) or a
// tick (in_cmd = 1, one bit period). While the queue holds a byte, successive
// ticks send a start bit, the eight data bits lsb first and a stop bit, after
// which the byte leaves the queue; ticks with an empty queue leave the line as
// it is. A push to a full queue is dropped and flagged in out_push_dropped.
// The block takes one request every clock cycle while in_stall is low and
// returns one result per request from a registered two-entry result buffer,
// which keeps requests flowing while out_stall is held; in_stall rises only
// once both entries wait. The queue memory has one write port (pushes)
// and one read port: the head byte is read during the start-bit tick and its
// registered read data serves the eight data-bit ticks that follow. The line
// resets idle high and the queue empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_tx_serializer_fifo #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_cmd,
  input  wire logic [uts_pkg::BYTE_W-1:0]  in_data_byte,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_tx_line,
  output logic                             out_busy_res,
  output logic [uts_pkg::COUNT_W-1:0]      out_queue_count,
  output logic                             out_push_dropped
);

  // queue index and fill count widths follow the depth
  localparam int unsigned IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic                       acc;
  logic                       buf_full;
  uts_pkg::cmd_t              cmd;
  uts_pkg::mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]           wr_addr;
  logic [IDX_W-1:0]           rd_addr;
  logic [uts_pkg::BYTE_W-1:0] rd_data;
  uts_pkg::res_t              res_new;
  uts_pkg::res_t              res_out;

  // a request is taken whenever the result buffer has room
  assign in_stall = buf_full;
  assign acc      = in_valid && !buf_full;
  assign cmd      = uts_pkg::cmd_t'(in_cmd);

  // pointers, fill count and the bit sequencer
  uts_framer #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDX_W       (IDX_W),
    .FILL_W      (FILL_W)
  ) u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .cmd       (cmd),
    .rd_data   (rd_data),
    .mem_ctl   (mem_ctl),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .res       (res_new)
  );

  // byte storage, written on push, read at the start bit
  uts_queue_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_queue_mem (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (in_data_byte),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // result register with skid entry
  uts_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_res  (res_new),
    .pop_stall (out_stall),
    .full      (buf_full),
    .res_valid (out_valid),
    .res_out   (res_out)
  );

  assign out_tx_line      = res_out.tx_line;
  assign out_busy_res     = res_out.busy_res;
  assign out_queue_count  = res_out.queue_count;
  assign out_push_dropped = res_out.push_dropped;

endmodule

`default_nettype wire

@@ design/uts_queue_mem.sv @@
// ----------------------------------------------------------------------------
// uts_queue_mem
// Byte queue storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module uts_queue_mem #(
  parameter int unsigned QUEUE_DEPTH = 256,
  parameter int unsigned IDX_W       = 8
) (
  input  wire logic                       clk,
  input  wire uts_pkg::mem_ctl_t          mem_ctl,
  input  wire logic [IDX_W-1:0]           wr_addr,
  input  wire logic [uts_pkg::BYTE_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0]           rd_addr,
  output logic      [uts_pkg::BYTE_W-1:0] rd_data_r
);

  logic [uts_pkg::BYTE_W-1:0] store [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data_r <= store[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/uts_framer.sv @@
// ----------------------------------------------------------------------------
// uts_framer
// Queue pointers, fill count and 8N1 framing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module uts_framer #(
  parameter int unsigned QUEUE_DEPTH = 256,
  parameter int unsigned IDX_W       = 8,
  parameter int unsigned FILL_W      = 9
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       acc,
  input  wire uts_pkg::cmd_t              cmd,
  input  wire logic [uts_pkg::BYTE_W-1:0] rd_data,
  output uts_pkg::mem_ctl_t               mem_ctl,
  output logic      [IDX_W-1:0]           wr_addr,
  output logic      [IDX_W-1:0]           rd_addr,
  output uts_pkg::res_t                   res
);

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(QUEUE_DEPTH);

  logic [IDX_W-1:0]            head_r, head_nxt;
  logic [IDX_W-1:0]            tail_r, tail_nxt;
  logic [FILL_W-1:0]           fill_r, fill_nxt;
  logic [uts_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                        line_r, line_nxt;
  logic                        full;
  logic                        dropped;
  logic                        wr_en;
  logic                        rd_en;

  assign full = (fill_r == FULL_CNT);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    phase_nxt = phase_r;
    line_nxt  = line_r;
    dropped   = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    if (cmd == uts_pkg::CMD_PUSH) begin
      if (full) begin
        dropped = 1'b1;
      end else begin
        wr_en    = acc;
        tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
        fill_nxt = fill_r + 1'b1;
      end
    end else if (fill_r != '0) begin
      priority if (phase_r == uts_pkg::PHASE_START) begin
        // fetch the head byte while the start bit goes out
        line_nxt  = uts_pkg::LINE_START;
        phase_nxt = phase_r + 1'b1;
        rd_en     = acc;
      end else if (phase_r < uts_pkg::PHASE_STOP) begin
        line_nxt  = rd_data[uts_pkg::BITSEL_W'(phase_r - 1'b1)];
        phase_nxt = phase_r + 1'b1;
      end else begin
        line_nxt  = uts_pkg::LINE_STOP;
        head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
        fill_nxt  = fill_r - 1'b1;
        phase_nxt = uts_pkg::PHASE_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      phase_r <= uts_pkg::PHASE_START;
      line_r  <= uts_pkg::LINE_IDLE;
    end else if (acc) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
    end
  end

  assign mem_ctl.wr_en = wr_en;
  assign mem_ctl.rd_en = rd_en;
  assign wr_addr       = tail_r;
  assign rd_addr       = head_r;

  assign res.tx_line      = line_nxt;
  assign res.busy_res     = (fill_nxt != '0);
  assign res.queue_count  = uts_pkg::COUNT_W'(fill_nxt);
  assign res.push_dropped = dropped;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond queue depth");

  a_phase_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != uts_pkg::PHASE_START |-> fill_r != '0)
    else $error("frame in progress with empty queue");

  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= uts_pkg::PHASE_STOP)
    else $error("phase beyond stop bit");

  a_drop_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    acc && cmd == uts_pkg::CMD_PUSH && full |=> fill_r == $past(fill_r) &&
      tail_r == $past(tail_r))
    else $error("dropped push changed the queue");
`endif

endmodule

`default_nettype wire

@@ design/uts_out_buf.sv @@
// ----------------------------------------------------------------------------
// uts_out_buf
// Two-entry result buffer so a request is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module uts_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire uts_pkg::res_t push_res,
  input  wire logic          pop_stall,
  output logic               full,
  output logic               res_valid,
  output uts_pkg::res_t      res_out
);

  logic [1:0]    cnt_r, cnt_nxt;
  uts_pkg::res_t head_r, head_nxt;
  uts_pkg::res_t spare_r, spare_nxt;
  logic          pop;

  assign pop       = (cnt_r != 2'd0) && !pop_stall;
  assign full      = (cnt_r == 2'd2);
  assign res_valid = (cnt_r != 2'd0);
  assign res_out   = head_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    spare_nxt = spare_r;
    unique case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_res;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_res;
        end else if (push) begin
          spare_nxt = push_res;
          cnt_nxt   = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = spare_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: begin
        cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

endmodule

`default_nettype wire

@@ test/uart_tx_serializer_fifo_tb.sv @@
// ----------------------------------------------------------------------------
// uart_tx_serializer_fifo_tb
// Self-checking bench for the 8N1 transmitter with byte queue: requests are
// sent in bursts, each result is checked against a line-level predictor of the
// queue and the framing phase, and the result side stalls on its own pattern.
// ----------------------------------------------------------------------------

module uart_tx_serializer_fifo_tb;

  localparam int unsigned QUEUE_DEPTH     = 256;
  localparam int unsigned IDLE_LIMIT      = 2000;  // cycles with no handshake at all
  localparam int unsigned HOLDOFF_CYCLES  = 80;    // long result-side hold-off
  localparam int unsigned RANDOM_REQUESTS = 1150;
  localparam int unsigned SETTLE_CYCLES   = 16;

  // dut ports, inputs all known from time zero
  logic                        clk          = 1'b0;
  logic                        rst_n        = 1'b0;
  logic                        in_valid     = 1'b0;
  logic                        in_cmd       = 1'b0;
  logic [uts_pkg::BYTE_W-1:0]  in_data_byte = '0;
  logic                        out_stall    = 1'b0;
  logic                        in_stall;
  logic                        out_valid;
  logic                        out_tx_line;
  logic                        out_busy_res;
  logic [uts_pkg::COUNT_W-1:0] out_queue_count;
  logic                        out_push_dropped;

  uart_tx_serializer_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tx_line     (out_tx_line),
    .out_busy_res    (out_busy_res),
    .out_queue_count (out_queue_count),
    .out_push_dropped(out_push_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor: its own copy of the byte queue and the framer
  // --------------------------------------------------------------------------
  logic [uts_pkg::BYTE_W-1:0]  tx_bytes [QUEUE_DEPTH];
  int unsigned                 q_head  = 0;
  int unsigned                 q_tail  = 0;
  int unsigned                 q_fill  = 0;
  logic [uts_pkg::PHASE_W-1:0] q_phase = uts_pkg::PHASE_START;
  logic                        q_line  = uts_pkg::LINE_IDLE;

  uts_pkg::res_t line_expect [$];   // results still owed by the block, oldest first
  int unsigned   mismatch_count = 0;
  int unsigned   result_index   = 0;
  int unsigned   sent_requests  = 0; // every request accepted so far
  int            burst_left     = 0;

  // advances the predictor by one request and returns the result it owes
  function automatic uts_pkg::res_t predict_line(input uts_pkg::cmd_t kind,
                                                 input logic [uts_pkg::BYTE_W-1:0] data);
    uts_pkg::res_t r;
    r.push_dropped = 1'b0;
    if (kind == uts_pkg::CMD_PUSH) begin
      if (q_fill >= QUEUE_DEPTH) begin
        r.push_dropped = 1'b1;             // full queue: byte lost, nothing moves
      end else begin
        tx_bytes[q_tail] = data;
        q_tail = (q_tail == QUEUE_DEPTH - 1) ? 0 : q_tail + 1;
        q_fill++;
      end
    end else if (q_fill != 0) begin        // tick on an empty queue keeps the line
      if (q_phase == uts_pkg::PHASE_START) begin
        q_line  = uts_pkg::LINE_START;
        q_phase = q_phase + 1'b1;
      end else if (q_phase < uts_pkg::PHASE_STOP) begin
        q_line  = tx_bytes[q_head][q_phase - 1'b1];  // data bits lsb first
        q_phase = q_phase + 1'b1;
      end else begin
        q_line  = uts_pkg::LINE_STOP;      // stop bit, byte leaves the queue
        q_head  = (q_head == QUEUE_DEPTH - 1) ? 0 : q_head + 1;
        q_fill--;
        q_phase = uts_pkg::PHASE_START;
      end
    end
    r.tx_line     = q_line;
    r.busy_res    = (q_fill != 0);
    r.queue_count = uts_pkg::COUNT_W'(q_fill);
    return r;
  endfunction

  // byte values with the extremes well represented
  function automatic logic [uts_pkg::BYTE_W-1:0] random_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return uts_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // request side: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  task automatic send_request(input uts_pkg::cmd_t kind,
                              input logic [uts_pkg::BYTE_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_cmd       <= kind;
    in_data_byte <= data;
    // accepted at the first edge that finds no stall
    do @(posedge clk); while (in_stall);
    sent_requests++;
    line_expect.push_back(predict_line(kind, data));
  endtask

  task automatic send_push(input logic [uts_pkg::BYTE_W-1:0] data);
    send_request(uts_pkg::CMD_PUSH, data);
  endtask

  // ticks carry a random, ignored byte
  task automatic send_tick();
    send_request(uts_pkg::CMD_TICK, uts_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // drops valid and waits for the clock so that no later drive lands in this step
  task automatic release_sender();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    release_sender();
    while (line_expect.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result side: stall pattern of its own, plus a long hold-off on request
  // --------------------------------------------------------------------------
  int unsigned hold_requests = 0;   // bumped by a test to ask for a hold-off
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned mode_left     = 0;
  int unsigned stall_mode    = 0;

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLDOFF_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);   // clear, light or heavy stalling
      mode_left  = $urandom_range(16, 160);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("result %0d: %s is %0d, expected %0d", result_index, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    uts_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (line_expect.size() == 0) begin
        report_mismatch("result with none outstanding, valid", 1, 0);
      end else begin
        want = line_expect.pop_front();
        if (out_tx_line !== want.tx_line)
          report_mismatch("tx_line", out_tx_line, want.tx_line);
        if (out_busy_res !== want.busy_res)
          report_mismatch("busy_res", out_busy_res, want.busy_res);
        if (out_queue_count !== want.queue_count)
          report_mismatch("queue_count", out_queue_count, want.queue_count);
        if (out_push_dropped !== want.push_dropped)
          report_mismatch("push_dropped", out_push_dropped, want.push_dropped);
      end
      result_index++;
    end
  end

  // watchdog: too long without any handshake ends the run
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("uart_tx_serializer_fifo_tb failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // idle tick, all-zero and all-one bytes, a push landing mid-frame
  task automatic test_directed_frames();
    send_tick();                          // empty queue, line stays idle high
    send_push(8'h00);
    send_push(8'hFF);
    repeat (10) send_tick();              // whole frame of the zero byte
    repeat (4) send_tick();
    send_push(8'hA5);                     // queued behind the frame in flight
    repeat (6) send_tick();               // rest of the all-ones frame
  endtask

  // fill to the brim, drops on a full queue, one byte out and full again
  task automatic test_queue_full();
    while (q_fill < QUEUE_DEPTH) send_push(random_byte());
    repeat (3) send_push(random_byte());  // all dropped
    repeat (10) send_tick();              // one byte out, one slot free
    send_push(random_byte());
    send_push(random_byte());             // full again, dropped
  endtask

  // result side holds off for a long stretch while requests keep coming
  task automatic test_output_holdoff();
    hold_requests++;
    repeat (60) begin
      if ($urandom_range(0, 2) == 0) send_push(random_byte());
      else send_tick();
    end
  endtask

  // sender goes quiet until every owed result has come back
  task automatic test_idle_pause();
    repeat (3) send_push(random_byte());
    repeat (14) send_tick();
    wait_results_drained();
    repeat (20) send_tick();
  endtask

  // mostly whole frames with random content, some stray requests as noise
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned n;
    start = sent_requests;
    while (sent_requests - start < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(uts_pkg::cmd_t'($urandom_range(0, 1)),
                     uts_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_push(random_byte());
        // roughly enough ticks to send them, sometimes short, sometimes long
        repeat ($urandom_range(n * 10 - 4, n * 10 + 12)) send_tick();
      end
    end
  endtask

  initial begin
    // synchronous reset held low at the start, then released
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_output_holdoff();
    test_idle_pause();
    test_random_traffic();
    test_queue_full();
    test_output_holdoff();

    // let every owed result arrive, then watch for strays
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("uart_tx_serializer_fifo_tb passed");
    end else begin
      $display("uart_tx_serializer_fifo_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/uts_pkg.sv
design/uts_queue_mem.sv
design/uts_framer.sv
design/uts_out_buf.sv
design/uart_tx_serializer_fifo.sv
test/uart_tx_serializer_fifo_tb.sv
